// File: hw/rtl/wts_pkg.sv
// Package for the weekly timetable scheduler: constants, payload structs,
// codes and the control structs shared between the top level and the scan unit.
// Depends on nothing.
package wts_pkg;

  localparam int SCAN_HOURS = 168;
  localparam int KW         = $clog2(SCAN_HOURS);
  localparam int MASK_W     = 56;

  localparam logic [MASK_W-1:0] HOURS_0_TO_7_RST   = 56'h00_0000_0000_0000;
  localparam logic [MASK_W-1:0] HOURS_8_TO_15_RST  = 56'hFF_FFFF_FFFF_FF80;
  localparam logic [MASK_W-1:0] HOURS_16_TO_23_RST = 56'h00_0000_0FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_CHECK   = 2'd0,
    MODE_START_Q = 2'd1,
    MODE_STOP_Q  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_HOURS_0_TO_7   = 3'd0,
    CFG_HOURS_8_TO_15  = 3'd1,
    CFG_HOURS_16_TO_23 = 3'd2,
    CFG_TIMETABLE_ON   = 3'd3,
    CFG_AUTO_START     = 3'd4
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_STOP_SCAN,
    ST_START_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SCAN_NOP,
    SCAN_LOAD,
    SCAN_RUN
  } scan_op_e;

  typedef enum logic {
    KIND_STOP,
    KIND_START
  } scan_kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic       docked;
    logic [7:0] rain_hold_hours;
    logic       operator_docked;
    logic       work_left;
    logic       frame_completed;
  } in_item_t;

  typedef struct packed {
    logic       allowed_now;
    logic       start_now;
    logic       stop_now;
    logic       start_found;
    logic [2:0] start_day;
    logic [4:0] start_hour;
    logic       stop_found;
    logic [2:0] stop_day;
    logic [4:0] stop_hour;
    logic       query_answer;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        index;
    logic [MASK_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [MASK_W-1:0] hours_0_to_7;
    logic [MASK_W-1:0] hours_8_to_15;
    logic [MASK_W-1:0] hours_16_to_23;
    logic              timetable_on;
    logic              auto_start_allowed;
  } cfg_regs_t;

  typedef struct packed {
    scan_op_e   op;
    scan_kind_e kind;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic       trig;
  } scan_cmd_t;

  typedef struct packed {
    logic       allowed;
    logic       done;
    logic       found;
    logic [4:0] hour;
    logic [2:0] weekday;
  } scan_sts_t;

endpackage

// File: hw/rtl/wts_in_if.sv
// Input item channel of the weekly timetable scheduler.
// Depends on wts_pkg for the payload type.
interface wts_in_if;
  logic             valid;
  logic             ready;
  wts_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/wts_out_if.sv
// Result item channel of the weekly timetable scheduler.
// Depends on wts_pkg for the payload type.
interface wts_out_if;
  logic              valid;
  logic              ready;
  wts_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/wts_cfg_if.sv
// Configuration write channel of the weekly timetable scheduler.
// Depends on wts_pkg for the payload type.
interface wts_cfg_if;
  logic               valid;
  logic               ready;
  wts_pkg::cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/weekly_timetable_scheduler.sv
// Weekly timetable scheduler top level: configuration registers, trigger
// latches, sequencer and output register. Depends on wts_pkg, the three
// channel interfaces and wts_scan_unit.
//
//  channel | dir | payload                         | transfer when
//  --------+-----+---------------------------------+----------------------------
//  in_i    | in  | mode, hour, weekday, flags, hold | in_i.valid && in_i.ready
//  out_o   | out | allowed/start/stop flags, times  | out_o.valid && out_o.ready
//  cfg_i   | in  | register index, 56-bit data      | cfg_i.valid (ready is high)
//
// A check item passes through EVAL, STOP_SCAN, START_SCAN and DONE before the
// next possible input transfer; its result is loaded into the output register
// from DONE. The shared scan unit walks one hour per cycle, first for a stop
// edge, then for a start.
// A pass ends early on a hit and finishes at once when it cannot find anything.
// Query items and unused modes skip both scans; their result passes through the
// result register into the output register.
// Reset loads the register defaults and clears all latches; no sweep follows.
// A result waits in the output register; the block takes the next item
// meanwhile and holds its own result back until that register is free.
module weekly_timetable_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  wts_in_if.sink    in_i,
  wts_out_if.source out_o,
  wts_cfg_if.sink   cfg_i
);
  import wts_pkg::*;

  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  out_item_t res_q, res_d;
  out_item_t out_data_q, out_data_d;
  logic      out_valid_q, out_valid_d;
  cfg_regs_t cfg_q, cfg_d;
  logic      last_allowed_q, last_allowed_d;
  logic      start_latch_q, start_latch_d;
  logic      stop_latch_q, stop_latch_d;
  logic      start_pending_q, start_pending_d;
  logic      stop_pending_q, stop_pending_d;

  scan_cmd_t cmd;
  scan_sts_t sts;
  logic      in_ready;
  logic      load_out;
  logic      changed;
  logic      pend;

  wts_scan_unit u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // Configuration: always ready; writes beyond the list are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_HOURS_0_TO_7:   cfg_d.hours_0_to_7       = cfg_i.data.data;
        CFG_HOURS_8_TO_15:  cfg_d.hours_8_to_15      = cfg_i.data.data;
        CFG_HOURS_16_TO_23: cfg_d.hours_16_to_23     = cfg_i.data.data;
        CFG_TIMETABLE_ON:   cfg_d.timetable_on       = cfg_i.data.data[0];
        CFG_AUTO_START:     cfg_d.auto_start_allowed = cfg_i.data.data[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.data.mode == MODE_CHECK) ? ST_EVAL : ST_DONE;
        end
      end
      ST_EVAL:       state_d = ST_STOP_SCAN;
      ST_STOP_SCAN:  if (sts.done) state_d = ST_START_SCAN;
      ST_START_SCAN: if (sts.done) state_d = ST_DONE;
      ST_DONE:       if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: unit commands, latch and result updates
  always_comb begin
    in_ready        = 1'b0;
    load_out        = 1'b0;
    changed         = 1'b0;
    pend            = 1'b0;
    cmd             = '{op: SCAN_NOP, kind: KIND_STOP, hour: '0, weekday: '0, trig: 1'b0};
    item_d          = item_q;
    res_d           = res_q;
    last_allowed_d  = last_allowed_q;
    start_latch_d   = start_latch_q;
    stop_latch_d    = stop_latch_q;
    start_pending_d = start_pending_q;
    stop_pending_d  = stop_pending_q;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          item_d = in_i.data;
          res_d  = '0;
          case (in_i.data.mode)
            MODE_CHECK: begin
              // Point the unit at the current hour so the next cycle reads it
              cmd.op      = SCAN_LOAD;
              cmd.hour    = in_i.data.hour;
              cmd.weekday = in_i.data.weekday;
            end
            MODE_START_Q: begin
              res_d.query_answer = start_pending_q;
              start_latch_d      = start_latch_q | start_pending_q;
            end
            MODE_STOP_Q: begin
              res_d.query_answer = stop_pending_q;
              stop_latch_d       = stop_latch_q | stop_pending_q;
            end
            default: res_d = '0;
          endcase
        end
      end
      ST_EVAL: begin
        // Clear both latches when the allowed state has moved
        changed           = (sts.allowed != last_allowed_q);
        res_d.allowed_now = sts.allowed;
        if (changed) begin
          last_allowed_d = sts.allowed;
          start_latch_d  = 1'b0;
          stop_latch_d   = 1'b0;
        end
        cmd.op      = SCAN_RUN;
        cmd.kind    = KIND_STOP;
        cmd.hour    = item_q.hour;
        cmd.weekday = item_q.weekday;
        cmd.trig    = changed ? 1'b0 : stop_latch_q;
      end
      ST_STOP_SCAN: begin
        if (sts.done) begin
          pend = sts.found && (sts.weekday == item_q.weekday) &&
                 (sts.hour == item_q.hour);
          stop_pending_d   = pend;
          res_d.stop_now   = pend;
          res_d.stop_found = sts.found;
          res_d.stop_day   = sts.found ? sts.weekday : 3'd0;
          res_d.stop_hour  = sts.found ? sts.hour : 5'd0;
          cmd.op      = SCAN_RUN;
          cmd.kind    = KIND_START;
          cmd.hour    = item_q.hour;
          cmd.weekday = item_q.weekday;
          cmd.trig    = start_latch_q;
        end
      end
      ST_START_SCAN: begin
        if (sts.done) begin
          pend = sts.found && (sts.weekday == item_q.weekday) &&
                 (sts.hour == item_q.hour);
          start_pending_d   = pend;
          res_d.start_now   = pend;
          res_d.start_found = sts.found;
          res_d.start_day   = sts.found ? sts.weekday : 3'd0;
          res_d.start_hour  = sts.found ? sts.hour : 5'd0;
        end
      end
      ST_DONE: begin
        load_out = !out_valid_q || out_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Output register: load a finished result, drop it after its transfer
  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_data_d  = res_q;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                  <= ST_IDLE;
      item_q                   <= '0;
      res_q                    <= '0;
      out_data_q               <= '0;
      out_valid_q              <= 1'b0;
      cfg_q.hours_0_to_7       <= HOURS_0_TO_7_RST;
      cfg_q.hours_8_to_15      <= HOURS_8_TO_15_RST;
      cfg_q.hours_16_to_23     <= HOURS_16_TO_23_RST;
      cfg_q.timetable_on       <= 1'b0;
      cfg_q.auto_start_allowed <= 1'b1;
      last_allowed_q           <= 1'b0;
      start_latch_q            <= 1'b0;
      stop_latch_q             <= 1'b0;
      start_pending_q          <= 1'b0;
      stop_pending_q           <= 1'b0;
    end else begin
      state_q         <= state_d;
      item_q          <= item_d;
      res_q           <= res_d;
      out_data_q      <= out_data_d;
      out_valid_q     <= out_valid_d;
      cfg_q           <= cfg_d;
      last_allowed_q  <= last_allowed_d;
      start_latch_q   <= start_latch_d;
      stop_latch_q    <= stop_latch_d;
      start_pending_q <= start_pending_d;
      stop_pending_q  <= stop_pending_d;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: hw/rtl/wts_scan_unit.sv
// Shared scan unit: looks up one slot of the week table per cycle and steps
// hour by hour, hunting for a stop or a start event. Depends on wts_pkg.
module wts_scan_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wts_pkg::cfg_regs_t cfg_i,
  input  wts_pkg::in_item_t  item_i,
  input  wts_pkg::scan_cmd_t cmd_i,
  output wts_pkg::scan_sts_t sts_o
);
  import wts_pkg::*;

  logic       run_q, run_d;
  logic       done_q, done_d;
  logic       found_q, found_d;
  scan_kind_e kind_q, kind_d;
  logic [4:0] hr_q, hr_d;
  logic [2:0] day_q, day_d;
  logic [KW-1:0] k_q, k_d;
  logic       level_q, level_d;
  logic       trig_q, trig_d;
  logic [4:0] fh_q, fh_d;
  logic [2:0] fd_q, fd_d;

  logic       slot;
  logic [5:0] bit_sel;
  logic [MASK_W-1:0] mask_sel;
  logic [7:0] k_ext;
  logic       past_hold;
  logic       edge_seen;
  logic       hit;
  logic       upd_en;
  logic       skip;

  // Slot lookup: day mask bank by hour group, bit 7*(hour mod 8) + day
  always_comb begin
    case (hr_q[4:3])
      2'd0:    mask_sel = cfg_i.hours_0_to_7;
      2'd1:    mask_sel = cfg_i.hours_8_to_15;
      default: mask_sel = cfg_i.hours_16_to_23;
    endcase
    bit_sel = ({3'b000, hr_q[2:0]} * 6'd7) + {3'b000, day_q};
    if (!cfg_i.timetable_on) begin
      slot = 1'b1;
    end else if (hr_q > 5'd23 || day_q > 3'd6) begin
      slot = 1'b0;
    end else begin
      slot = mask_sel[bit_sel];
    end
  end

  assign k_ext     = 8'(k_q);
  assign past_hold = (k_ext >= item_i.rain_hold_hours);
  assign edge_seen = (slot != level_q);

  always_comb begin
    if (kind_q == KIND_STOP) begin
      hit    = edge_seen && !slot && !trig_q;
      upd_en = 1'b1;
    end else begin
      upd_en = past_hold && cfg_i.timetable_on;
      if (!past_hold) begin
        hit = 1'b0;
      end else if (!cfg_i.timetable_on) begin
        hit = !item_i.operator_docked && item_i.work_left;
      end else begin
        hit = (edge_seen && slot && !trig_q) ||
              (slot && !item_i.operator_docked &&
               (!item_i.frame_completed || item_i.work_left));
      end
    end
  end

  // A pass that can never find anything finishes at once
  assign skip = (cmd_i.kind == KIND_STOP) ? !cfg_i.timetable_on :
                (!cfg_i.auto_start_allowed || !item_i.docked);

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    found_d = found_q;
    kind_d  = kind_q;
    hr_d    = hr_q;
    day_d   = day_q;
    k_d     = k_q;
    level_d = level_q;
    trig_d  = trig_q;
    fh_d    = fh_q;
    fd_d    = fd_q;
    case (cmd_i.op)
      SCAN_LOAD: begin
        hr_d  = cmd_i.hour;
        day_d = cmd_i.weekday;
      end
      SCAN_RUN: begin
        hr_d    = cmd_i.hour;
        day_d   = cmd_i.weekday;
        kind_d  = cmd_i.kind;
        k_d     = '0;
        level_d = (cmd_i.kind == KIND_STOP);
        trig_d  = cmd_i.trig;
        if (skip) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          run_d   = 1'b0;
        end else begin
          run_d = 1'b1;
        end
      end
      default: begin
        if (run_q) begin
          if (hit) begin
            run_d   = 1'b0;
            done_d  = 1'b1;
            found_d = 1'b1;
            fh_d    = hr_q;
            fd_d    = day_q;
          end else if (k_q == KW'(SCAN_HOURS - 1)) begin
            run_d   = 1'b0;
            done_d  = 1'b1;
            found_d = 1'b0;
          end else begin
            k_d = k_q + KW'(1);
            if (upd_en && edge_seen) begin
              trig_d  = 1'b0;
              level_d = slot;
            end
            // Advance one hour; any hour from 23 up wraps into the next day
            if (hr_q >= 5'd23) begin
              hr_d  = '0;
              day_d = (day_q >= 3'd6) ? 3'd0 : day_q + 3'd1;
            end else begin
              hr_d = hr_q + 5'd1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      kind_q  <= KIND_STOP;
      hr_q    <= '0;
      day_q   <= '0;
      k_q     <= '0;
      level_q <= 1'b0;
      trig_q  <= 1'b0;
      fh_q    <= '0;
      fd_q    <= '0;
    end else begin
      run_q   <= run_d;
      done_q  <= done_d;
      found_q <= found_d;
      kind_q  <= kind_d;
      hr_q    <= hr_d;
      day_q   <= day_d;
      k_q     <= k_d;
      level_q <= level_d;
      trig_q  <= trig_d;
      fh_q    <= fh_d;
      fd_q    <= fd_d;
    end
  end

  assign sts_o.allowed = slot;
  assign sts_o.done    = done_q;
  assign sts_o.found   = found_q;
  assign sts_o.hour    = fh_q;
  assign sts_o.weekday = fd_q;

endmodule

// File: hw/rtl/wts_checker.sv
// Port-level checker for the weekly timetable scheduler and its bind.
// Depends on wts_pkg and the top level's channel interfaces.
module wts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input wts_pkg::out_item_t out_data_i
);
  import wts_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // Every item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while the previous one is in work");

  // A stop in the current hour means the hour itself is not allowed
  a_stop_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.stop_now |-> !out_data_i.allowed_now &&
                                           out_data_i.stop_found)
    else $error("stop_now without a stop edge at the current hour");

endmodule

bind weekly_timetable_scheduler wts_checker u_wts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: tb/testbench.sv
// Self-checking testbench for weekly_timetable_scheduler: directed and random check
// and query items against a cycle-free model of the weekly scan, under random idling.
// Depends on wts_pkg and the three channel interfaces of the RTL.
module testbench;
  import wts_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  // Longest check item: two full scans plus the sequencer's own cycles.
  localparam int unsigned DRAIN_CYCLES   = 2 * SCAN_HOURS + 16;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 108;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam logic [2:0]  CFG_PAST_END   = 3'd5;
  localparam logic [2:0]  CFG_TOP_INDEX  = 3'd7;

  typedef enum int {RX_OPEN, RX_DUTY, RX_SPARSE, RX_COIN} rx_style_e;
  typedef enum int {BANK_CLEAR, BANK_FULL, BANK_NOISE, BANK_WINDOW, BANK_SPARSE} bank_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wts_in_if  in_if ();
  wts_out_if out_if ();
  wts_cfg_if cfg_if ();

  weekly_timetable_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Everything the testbench drives comes from these registers, so every input
  // of the block holds a known value from the very first time step.
  logic       drv_valid = 1'b0;
  in_item_t   drv_item  = '0;
  logic       rcv_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  cfg_write_t cfg_word  = '0;

  assign in_if.valid  = drv_valid;
  assign in_if.data   = drv_item;
  assign out_if.ready = rcv_ready;
  assign cfg_if.valid = cfg_valid;
  assign cfg_if.data  = cfg_word;

  initial forever #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, reset values first.
  logic [MASK_W-1:0] tt_lo  = HOURS_0_TO_7_RST;
  logic [MASK_W-1:0] tt_mid = HOURS_8_TO_15_RST;
  logic [MASK_W-1:0] tt_hi  = HOURS_16_TO_23_RST;
  bit                tt_on   = 1'b0;
  bit                auto_ok = 1'b1;

  // Shadow copy of the trigger state.
  bit was_allowed    = 1'b0;
  bit start_latched  = 1'b0;
  bit stop_latched   = 1'b0;
  bit start_due      = 1'b0;
  bit stop_due       = 1'b0;

  in_item_t   pending_items[$];
  out_item_t  due_results[$];
  out_item_t  oldest_due;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Timetable model
  // ---------------------------------------------------------------------------

  // Permission of one hour of the week. With the table off every hour is open;
  // with it on, hours above 23 and weekday 7 are always closed.
  function automatic bit slot_open(input int unsigned hr, input int unsigned day);
    logic [MASK_W-1:0] bank;
    if (!tt_on) return 1'b1;
    if (hr > 23 || day > 6) return 1'b0;
    if (hr < 8) bank = tt_lo;
    else if (hr < 16) bank = tt_mid;
    else bank = tt_hi;
    return bank[7 * (hr % 8) + day];
  endfunction

  // Step one hour; any hour past 23 rolls to midnight of the next day.
  function automatic void next_hour(inout int unsigned hr, inout int unsigned day);
    hr++;
    if (hr > 23) begin
      day++;
      if (day > 6) day = 0;
      hr = 0;
    end
  endfunction

  // Look for the next open-to-closed edge. A set stop latch swallows the first
  // edge seen; the scan starts from an assumed open level.
  function automatic bit find_stop(input int unsigned hr0, input int unsigned day0,
                                   output int unsigned fh, output int unsigned fd);
    int unsigned hr;
    int unsigned day;
    bit          trig;
    bit          level;
    bit          a;
    hr    = hr0;
    day   = day0;
    trig  = stop_latched;
    level = 1'b1;
    fh    = 0;
    fd    = 0;
    if (!tt_on) return 1'b0;
    for (int unsigned k = 0; k < SCAN_HOURS; k++) begin
      a = slot_open(hr, day);
      if (a != level) begin
        if (!a && !trig) begin
          fh = hr;
          fd = day;
          return 1'b1;
        end
        trig  = 1'b0;
        level = a;
      end
      next_hour(hr, day);
    end
    return 1'b0;
  endfunction

  // Look for the next start edge or open hour with work to do, skipping the
  // leading rain hold hours. Without the table only the work flags decide.
  function automatic bit find_start(input in_item_t it,
                                    output int unsigned fh, output int unsigned fd);
    int unsigned hr;
    int unsigned day;
    bit          trig;
    bit          level;
    bit          a;
    hr    = it.hour;
    day   = it.weekday;
    trig  = start_latched;
    level = 1'b0;
    fh    = 0;
    fd    = 0;
    if (!auto_ok || !it.docked) return 1'b0;
    for (int unsigned k = 0; k < SCAN_HOURS; k++) begin
      if (k >= it.rain_hold_hours) begin
        if (!tt_on) begin
          if (!it.operator_docked && it.work_left) begin
            fh = hr;
            fd = day;
            return 1'b1;
          end
        end else begin
          a = slot_open(hr, day);
          if (a != level) begin
            if (a && !trig) begin
              fh = hr;
              fd = day;
              return 1'b1;
            end
            trig  = 1'b0;
            level = a;
          end
          if (a && !it.operator_docked && (!it.frame_completed || it.work_left)) begin
            fh = hr;
            fd = day;
            return 1'b1;
          end
        end
      end
      next_hour(hr, day);
    end
    return 1'b0;
  endfunction

  // Result of one accepted item; updates the shadow trigger state.
  function automatic out_item_t next_events(input in_item_t it);
    out_item_t   r;
    int unsigned sh;
    int unsigned sd;
    int unsigned th;
    int unsigned td;
    bit          a;
    bit          sf;
    bit          tf;
    r = '0;
    if (it.mode == MODE_CHECK) begin
      a = slot_open(it.hour, it.weekday);
      // A change of permission re-arms both triggers.
      if (a != was_allowed) begin
        was_allowed   = a;
        start_latched = 1'b0;
        stop_latched  = 1'b0;
      end
      tf = find_stop(it.hour, it.weekday, th, td);
      stop_due = tf && td == it.weekday && th == it.hour;
      sf = find_start(it, sh, sd);
      start_due = sf && sd == it.weekday && sh == it.hour;
      r.allowed_now = a;
      r.start_now   = start_due;
      r.stop_now    = stop_due;
      r.start_found = sf;
      r.start_day   = sf ? 3'(sd) : 3'd0;
      r.start_hour  = sf ? 5'(sh) : 5'd0;
      r.stop_found  = tf;
      r.stop_day    = tf ? 3'(td) : 3'd0;
      r.stop_hour   = tf ? 5'(th) : 5'd0;
    end else if (it.mode == MODE_START_Q) begin
      if (start_due) start_latched = 1'b1;
      r.query_answer = start_due;
    end else if (it.mode == MODE_STOP_Q) begin
      if (stop_due) stop_latched = 1'b1;
      r.query_answer = stop_due;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_item(input logic [1:0] mode, input int unsigned hour,
                                     input int unsigned day, input bit docked,
                                     input int unsigned hold, input bit op,
                                     input bit work, input bit done);
    in_item_t it;
    it.mode            = mode;
    it.hour            = 5'(hour);
    it.weekday         = 3'(day);
    it.docked          = docked;
    it.rain_hold_hours = 8'(hold);
    it.operator_docked = op;
    it.work_left       = work;
    it.frame_completed = done;
    pending_items.push_back(it);
  endfunction

  // Day masks for one bank of eight hours starting at hour base.
  function automatic logic [MASK_W-1:0] bank_pattern(input bank_style_e style,
                                                     input int unsigned lo,
                                                     input int unsigned hi,
                                                     input logic [6:0] days,
                                                     input int unsigned base);
    logic [MASK_W-1:0] v;
    v = '0;
    case (style)
      BANK_CLEAR: v = '0;
      BANK_FULL:  v = '1;
      BANK_NOISE: v = MASK_W'({$urandom, $urandom});
      BANK_WINDOW: begin
        for (int unsigned h = 0; h < 8; h++)
          if (base + h >= lo && base + h <= hi) v[7 * h +: 7] = days;
      end
      default: begin
        for (int i = 0; i < 4; i++) v[$urandom_range(0, MASK_W - 1)] = 1'b1;
      end
    endcase
    return v;
  endfunction

  // One register write; the shadow copy follows at the transfer.
  task automatic write_reg(input logic [2:0] idx, input logic [MASK_W-1:0] val);
    @(posedge clk_i);
    cfg_valid      <= 1'b1;
    cfg_word.index <= idx;
    cfg_word.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_HOURS_0_TO_7:   tt_lo   = val;
      CFG_HOURS_8_TO_15:  tt_mid  = val;
      CFG_HOURS_16_TO_23: tt_hi   = val;
      CFG_TIMETABLE_ON:   tt_on   = val[0];
      CFG_AUTO_START:     auto_ok = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued item has gone in and every result has come back.
  task automatic wait_idle();
    while (pending_items.size() != 0 || drv_valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length separated by random gaps. Now and
  // then a burst waits until every outstanding result has arrived.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned burst_no;
  bit          drain_hold;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_item   <= '0;
      burst_left = 1;
      gap_left   = 0;
      burst_no   = 0;
      drain_hold = 1'b0;
    end else begin
      // Predict at the transfer so the shadow state moves in input order.
      if (drv_valid && in_if.ready) due_results.push_back(next_events(drv_item));
      if (!drv_valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (drain_hold && due_results.size() != 0) begin
          drv_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          drv_valid <= 1'b0;
        end else begin
          drain_hold = 1'b0;
          drv_valid <= 1'b1;
          drv_item  <= pending_items.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Close the burst: pick the next length, the gap, and whether to drain.
            burst_no++;
            burst_left = $urandom_range(1, 20);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(20, 40);
              default:    gap_left = $urandom_range(1, 12);
            endcase
            drain_hold = (burst_no % 9 == 3) || ($urandom_range(0, 15) == 0);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest expectation, and
  // stall on a pattern that changes style at random.
  // ---------------------------------------------------------------------------
  rx_style_e   rx_style;
  int unsigned rx_left;
  int unsigned rx_period;
  int unsigned rx_duty;
  int unsigned rx_tick;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      rx_style  = RX_OPEN;
      rx_left   = 0;
      rx_period = 2;
      rx_duty   = 1;
      rx_tick   = 0;
    end else begin
      if (out_if.valid && rcv_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          oldest_due = due_results.pop_front();
          check_field("allowed_now",  out_if.data.allowed_now,  oldest_due.allowed_now);
          check_field("start_now",    out_if.data.start_now,    oldest_due.start_now);
          check_field("stop_now",     out_if.data.stop_now,     oldest_due.stop_now);
          check_field("start_found",  out_if.data.start_found,  oldest_due.start_found);
          check_field("start_day",    out_if.data.start_day,    oldest_due.start_day);
          check_field("start_hour",   out_if.data.start_hour,   oldest_due.start_hour);
          check_field("stop_found",   out_if.data.stop_found,   oldest_due.stop_found);
          check_field("stop_day",     out_if.data.stop_day,     oldest_due.stop_day);
          check_field("stop_hour",    out_if.data.stop_hour,    oldest_due.stop_hour);
          check_field("query_answer", out_if.data.query_answer, oldest_due.query_answer);
        end
      end
      if (rx_left == 0) begin
        rx_style  = rx_style_e'($urandom_range(0, 3));
        rx_left   = $urandom_range(100, 600);
        rx_period = $urandom_range(2, 40);
        rx_duty   = $urandom_range(1, rx_period - 1);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_style)
        RX_OPEN:   rcv_ready <= 1'b1;
        RX_DUTY:   rcv_ready <= (rx_tick % rx_period) < rx_duty;
        RX_SPARSE: rcv_ready <= $urandom_range(0, 3) != 0;
        default:   rcv_ready <= $urandom_range(0, 1) != 0;
      endcase
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, then random phases each under a fresh
  // configuration written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       hr;
    int unsigned       day;
    int unsigned       n;
    int unsigned       roll;
    int unsigned       hold;
    int unsigned       lo;
    int unsigned       hi;
    logic [6:0]        days;
    logic [MASK_W-1:0] val;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, table off: start from work flags alone.
    queue_item(MODE_CHECK,   0,  0, 1, 0,   0, 1, 0);   // start now at midnight Monday
    queue_item(MODE_START_Q, 0,  0, 0, 0,   0, 0, 0);   // yes, sets the start latch
    queue_item(MODE_STOP_Q,  31, 7, 1, 255, 1, 1, 1);   // no stop without a table
    queue_item(MODE_UNUSED,  31, 7, 1, 255, 1, 1, 1);   // ignored, all-zero result
    queue_item(MODE_CHECK,   31, 7, 1, 168, 0, 1, 0);   // hold covers the whole scan
    queue_item(MODE_CHECK,   23, 6, 1, 167, 0, 1, 1);   // start on the last scan hour
    queue_item(MODE_CHECK,   12, 3, 0, 0,   0, 1, 0);   // not docked
    queue_item(MODE_CHECK,   12, 3, 1, 0,   1, 1, 0);   // operator docked
    wait_idle();

    // Reset tables applied: open 9..19 every day.
    write_reg(CFG_TIMETABLE_ON, MASK_W'(1));
    queue_item(MODE_CHECK,   8,  0, 1, 0, 0, 1, 0);     // closed, start at 9
    queue_item(MODE_CHECK,   9,  0, 1, 0, 0, 1, 0);     // start edge this hour
    queue_item(MODE_START_Q, 9,  0, 1, 0, 0, 1, 0);
    queue_item(MODE_CHECK,   10, 0, 1, 0, 0, 0, 1);     // latched, frame done: next day
    queue_item(MODE_STOP_Q,  10, 0, 1, 0, 0, 0, 1);
    queue_item(MODE_CHECK,   20, 0, 1, 0, 0, 1, 0);     // stop edge this hour
    queue_item(MODE_STOP_Q,  20, 0, 1, 0, 0, 1, 0);
    queue_item(MODE_CHECK,   21, 0, 1, 0, 0, 1, 0);     // stop latched, next at 20 Tuesday
    queue_item(MODE_CHECK,   24, 3, 1, 0, 0, 1, 0);     // hour past 23 is closed
    queue_item(MODE_CHECK,   5,  7, 1, 0, 0, 1, 0);     // weekday 7 is closed
    wait_idle();

    // Extremes of the three hour banks and the autostart register, plus a write past the end of the list.
    write_reg(CFG_HOURS_0_TO_7, '1);
    write_reg(CFG_HOURS_8_TO_15, '0);
    write_reg(CFG_HOURS_16_TO_23, '1);
    write_reg(CFG_AUTO_START, {{(MASK_W - 1){1'b1}}, 1'b0});
    write_reg(CFG_PAST_END, MASK_W'({$urandom, $urandom}));
    queue_item(MODE_CHECK, 3,  2, 1, 0,   0, 1, 0);     // no autostart, stop at 8
    wait_idle();
    write_reg(CFG_AUTO_START, '1);
    queue_item(MODE_CHECK, 23, 6, 1, 255, 0, 1, 1);
    queue_item(MODE_CHECK, 15, 1, 1, 9,   0, 0, 1);     // hold runs past the open block
    wait_idle();

    // Random phases. Most items walk a clock hour by hour so that edges land on
    // the current hour; the rest are noise over the full field ranges.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      lo   = $urandom_range(0, 23);
      hi   = $urandom_range(lo, 23);
      days = 7'($urandom_range(1, 127));
      write_reg(CFG_HOURS_0_TO_7,
                bank_pattern(bank_style_e'($urandom_range(0, 4)), lo, hi, days, 0));
      write_reg(CFG_HOURS_8_TO_15,
                bank_pattern(bank_style_e'($urandom_range(0, 4)), lo, hi, days, 8));
      write_reg(CFG_HOURS_16_TO_23,
                bank_pattern(bank_style_e'($urandom_range(0, 4)), lo, hi, days, 16));
      val    = MASK_W'({$urandom, $urandom});
      val[0] = $urandom_range(0, 3) != 0;
      write_reg(CFG_TIMETABLE_ON, val);
      val    = MASK_W'({$urandom, $urandom});
      val[0] = $urandom_range(0, 7) != 0;
      write_reg(CFG_AUTO_START, val);
      if ($urandom_range(0, 2) == 0)
        write_reg(3'($urandom_range(CFG_PAST_END, CFG_TOP_INDEX)),
                  MASK_W'({$urandom, $urandom}));

      hr  = $urandom_range(0, 23);
      day = $urandom_range(0, 6);
      n   = 0;
      while (n < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: hold = 0;
            6, 7:             hold = $urandom_range(1, 24);
            8:                hold = $urandom_range(0, SCAN_HOURS);
            default:          hold = $urandom_range(150, 255);
          endcase
          queue_item(MODE_CHECK, hr, day, $urandom_range(0, 19) != 0, hold,
                     $urandom_range(0, 9) == 0, $urandom_range(0, 9) < 7,
                     $urandom_range(0, 9) < 3);
          n++;
          if ($urandom_range(0, 9) < 6) begin
            queue_item(MODE_START_Q, $urandom_range(0, 31), $urandom_range(0, 7),
                       $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1));
            n++;
          end
          if ($urandom_range(0, 9) < 6) begin
            queue_item(MODE_STOP_Q, $urandom_range(0, 31), $urandom_range(0, 7),
                       $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1));
            n++;
          end
          if ($urandom_range(0, 9) != 0) begin
            next_hour(hr, day);
          end else begin
            hr  = $urandom_range(0, 23);
            day = $urandom_range(0, 6);
          end
        end else if (roll < 95) begin
          queue_item(2'($urandom_range(0, 2)), $urandom_range(0, 31), $urandom_range(0, 7),
                     $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
          n++;
        end else begin
          // Unused mode: does not count toward the phase.
          queue_item(MODE_UNUSED, $urandom_range(0, 31), $urandom_range(0, 7),
                     $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: weekly_timetable_scheduler.f
hw/rtl/wts_pkg.sv
hw/rtl/wts_in_if.sv
hw/rtl/wts_out_if.sv
hw/rtl/wts_cfg_if.sv
hw/rtl/wts_scan_unit.sv
hw/rtl/weekly_timetable_scheduler.sv
hw/rtl/wts_checker.sv
tb/testbench.sv
